// File: sv/frame_brightness_segmenter_defines.svh
// ----------------------------------------------------------------------------
// Frame brightness segmenter assertion macros
// Shared property shorthands for the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef FRAME_BRIGHTNESS_SEGMENTER_DEFINES_SVH
`define FRAME_BRIGHTNESS_SEGMENTER_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define FBS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define FBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset
`define FBS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fbs_pkg.sv
// ----------------------------------------------------------------------------
// Frame brightness segmenter package
// Widths, luma weights, register codes and the records passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package fbs_pkg;

  // Sizing
  localparam int PIXEL_COUNT_BITS = 24;
  localparam int FRAME_COUNT_BITS = 32;

  localparam int COLOR_W  = 8;
  localparam int GREY_W   = 8;
  localparam int MEAN_W   = 16;
  localparam int SEG_W    = 32;

  // Pixel tally holds 2^PIXEL_COUNT_BITS itself
  localparam int TALLY_W  = PIXEL_COUNT_BITS + 1;
  localparam int SUM_W    = PIXEL_COUNT_BITS + GREY_W;
  localparam int FRAC_W   = MEAN_W - GREY_W;
  localparam int CMP_W    = PIXEL_COUNT_BITS + MEAN_W;

  // Frame index never exceeds the 32-bit output field
  localparam int FRAME_IDX_W = (FRAME_COUNT_BITS < SEG_W) ? FRAME_COUNT_BITS : SEG_W;

  // Luma weights, 14-bit fixed point
  localparam int LUMA_W     = 14;
  localparam int LUMA_SUM_W = COLOR_W + LUMA_W;
  localparam logic [LUMA_W-1:0] WEIGHT_B = LUMA_W'(1868);
  localparam logic [LUMA_W-1:0] WEIGHT_G = LUMA_W'(9617);
  localparam logic [LUMA_W-1:0] WEIGHT_R = LUMA_W'(4899);
  localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = LUMA_SUM_W'(1) << (LUMA_W - 1);

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = MEAN_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MEAN_THRESHOLD = 1'b0,
    REG_SELECT_DARK    = 1'b1
  } cfg_reg_t;

  // Totals of one finished frame
  typedef struct packed {
    logic              video_end;
    logic [SUM_W-1:0]  grey_sum;
    logic [CMP_W-1:0]  thr_sum;
  } frame_stat_t;

  // One reported segment
  typedef struct packed {
    logic [SEG_W-1:0] segment_number;
    logic [SEG_W-1:0] start_frame;
    logic [SEG_W-1:0] frame_length;
  } segment_t;

endpackage

`default_nettype wire

// File: sv/fbs_if.sv
// ----------------------------------------------------------------------------
// Frame brightness segmenter stream interfaces
// Valid/ready channels for input pixels and reported segments.
// ----------------------------------------------------------------------------
`default_nettype none

// Pixel channel
interface fbs_pixel_if import fbs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] red;
  logic               frame_end;
  logic               video_end;

  modport source (output valid, blue, green, red, frame_end, video_end, input ready);
  modport sink   (input valid, blue, green, red, frame_end, video_end, output ready);
endinterface

// Segment channel
interface fbs_segment_if import fbs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segment_number;
  logic [SEG_W-1:0] start_frame;
  logic [SEG_W-1:0] frame_length;

  modport source (output valid, segment_number, start_frame, frame_length, input ready);
  modport sink   (input valid, segment_number, start_frame, frame_length, output ready);
endinterface

`default_nettype wire

// File: sv/fbs_luma.sv
// ----------------------------------------------------------------------------
// Luma stage
// Converts one registered BGR pixel to rounded 8-bit grey and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module fbs_luma import fbs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [COLOR_W-1:0] blue,
  input  wire logic [COLOR_W-1:0] green,
  input  wire logic [COLOR_W-1:0] red,
  input  wire logic               frame_end,
  input  wire logic               video_end,
  output logic                    valid,
  output logic [GREY_W-1:0]       grey,
  output logic                    fend,
  output logic                    vend
);

  logic [LUMA_SUM_W-1:0] luma_acc;

  // Constant-weight products, rounded, top bits kept
  always_comb begin
    luma_acc = LUMA_SUM_W'(blue)  * LUMA_SUM_W'(WEIGHT_B)
             + LUMA_SUM_W'(green) * LUMA_SUM_W'(WEIGHT_G)
             + LUMA_SUM_W'(red)   * LUMA_SUM_W'(WEIGHT_R)
             + LUMA_ROUND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grey <= luma_acc[LUMA_SUM_W-1 -: GREY_W];
      fend <= frame_end;
      vend <= video_end;
    end
  end

endmodule

`default_nettype wire

// File: sv/fbs_run_tracker.sv
// ----------------------------------------------------------------------------
// Run tracker
// Judges each finished frame against the threshold and follows runs of
// qualifying frames; flags a segment when a run closes or the video ends inside one.
// ----------------------------------------------------------------------------
`default_nettype none

module fbs_run_tracker import fbs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        frame_valid,
  input  wire frame_stat_t frame,
  input  wire logic        select_dark,
  output logic             emit,
  output segment_t         result
);

  logic                   run_open;
  logic [FRAME_IDX_W-1:0] run_start;
  logic [SEG_W-1:0]       run_length;
  logic [SEG_W-1:0]       run_number;
  logic [FRAME_IDX_W-1:0] frame_index;

  logic [CMP_W-1:0]       lhs;
  logic                   qualifies;
  logic                   run_open_next;
  logic [FRAME_IDX_W-1:0] run_start_next;
  logic [SEG_W-1:0]       run_length_next;

  // Mean test: sum*256 against threshold*tally
  always_comb begin
    lhs       = CMP_W'({frame.grey_sum, {FRAC_W{1'b0}}});
    qualifies = select_dark ? (lhs <= frame.thr_sum) : (lhs > frame.thr_sum);
  end

  // Run update for this frame
  always_comb begin
    run_open_next   = run_open;
    run_start_next  = run_start;
    run_length_next = run_length;
    emit            = 1'b0;
    if (frame_valid) begin
      if (qualifies) begin
        if (run_open) begin
          if (run_length != '1) begin
            run_length_next = run_length + SEG_W'(1);
          end
        end else begin
          run_open_next   = 1'b1;
          run_start_next  = frame_index;
          run_length_next = SEG_W'(1);
        end
        emit = frame.video_end;
      end else if (run_open) begin
        emit = 1'b1;
      end
    end
    result.segment_number = run_number;
    result.start_frame    = SEG_W'(run_start_next);
    result.frame_length   = run_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open    <= 1'b0;
      run_start   <= '0;
      run_length  <= '0;
      run_number  <= SEG_W'(1);
      frame_index <= '0;
    end else if (en && frame_valid) begin
      if (frame.video_end) begin
        // New video starts with the next pixel
        run_open    <= 1'b0;
        run_start   <= '0;
        run_length  <= '0;
        run_number  <= SEG_W'(1);
        frame_index <= '0;
      end else begin
        run_open   <= emit ? 1'b0 : run_open_next;
        run_start  <= run_start_next;
        run_length <= emit ? '0 : run_length_next;
        if (emit && (run_number != '1)) begin
          run_number <= run_number + SEG_W'(1);
        end
        if (frame_index != '1) begin
          frame_index <= frame_index + FRAME_IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/frame_brightness_segmenter.sv
// ----------------------------------------------------------------------------
// Frame brightness segmenter
// Grey-converts a pixel stream, judges each frame's mean brightness against a
// threshold and reports runs of qualifying frames as segments.
//
//   channel    dir  handshake      contents
//   pixels     in   valid/ready    blue, green, red, frame_end, video_end
//   segments   out  valid/ready    segment_number, start_frame, frame_length
//   cfg        in   cfg_we         cfg_index, cfg_data (mean_threshold, select_dark)
//
// One pixel per cycle while the skid register is empty. A segment closed by a
// pixel passes through the input register, luma register, frame totals register
// and output register.
// Pixels stall only when the output register and the skid register both hold
// segments. Reset is synchronous and clears all run and counter state.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_brightness_segmenter import fbs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  fbs_pixel_if.sink                  pixels,
  fbs_segment_if.source              segments,
  input  wire logic                  cfg_we,
  input  wire cfg_reg_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [MEAN_W-1:0] mean_threshold;
  logic              select_dark;

  // Pipeline control
  logic en;

  // Input register
  logic               s1_valid;
  logic [COLOR_W-1:0] s1_blue;
  logic [COLOR_W-1:0] s1_green;
  logic [COLOR_W-1:0] s1_red;
  logic               s1_fend;
  logic               s1_vend;

  // Luma register
  logic              s2_valid;
  logic [GREY_W-1:0] s2_grey;
  logic              s2_fend;
  logic              s2_vend;

  // Frame accumulators
  logic [SUM_W-1:0]   grey_sum;
  logic [TALLY_W-1:0] pixel_tally;
  logic [CMP_W-1:0]   thr_sum;
  logic               take_pixel;
  logic [SUM_W-1:0]   grey_sum_next;
  logic [TALLY_W-1:0] pixel_tally_next;
  logic [CMP_W-1:0]   thr_sum_next;
  logic               frame_close;

  // Frame totals register
  logic        s3_valid;
  frame_stat_t s3_frame;

  // Run tracker result
  logic     res_emit;
  segment_t res;

  // Output and skid registers
  logic     out_valid;
  segment_t out_data;
  logic     skid_valid;
  segment_t skid_data;
  logic     out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_threshold <= '0;
      select_dark    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEAN_THRESHOLD: mean_threshold <= cfg_data[MEAN_W-1:0];
        REG_SELECT_DARK:    select_dark    <= cfg_data[0];
      endcase
    end
  end

  // The pipeline moves unless the skid register is occupied
  assign en           = !skid_valid;
  assign pixels.ready = en;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_blue  <= pixels.blue;
      s1_green <= pixels.green;
      s1_red   <= pixels.red;
      s1_fend  <= pixels.frame_end;
      s1_vend  <= pixels.video_end;
    end
  end

  // Grey conversion
  fbs_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .blue      (s1_blue),
    .green     (s1_green),
    .red       (s1_red),
    .frame_end (s1_fend),
    .video_end (s1_vend),
    .valid     (s2_valid),
    .grey      (s2_grey),
    .fend      (s2_fend),
    .vend      (s2_vend)
  );

  // Accumulate grey and threshold*tally; pixels past the tally limit are dropped
  always_comb begin
    take_pixel       = s2_valid && !pixel_tally[TALLY_W-1];
    grey_sum_next    = grey_sum;
    pixel_tally_next = pixel_tally;
    thr_sum_next     = thr_sum;
    if (take_pixel) begin
      grey_sum_next    = grey_sum + SUM_W'(s2_grey);
      pixel_tally_next = pixel_tally + TALLY_W'(1);
      thr_sum_next     = thr_sum + CMP_W'(mean_threshold);
    end
    frame_close = s2_valid && (s2_fend || s2_vend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grey_sum    <= '0;
      pixel_tally <= '0;
      thr_sum     <= '0;
      s3_valid    <= 1'b0;
    end else if (en) begin
      s3_valid <= frame_close;
      if (frame_close) begin
        grey_sum    <= '0;
        pixel_tally <= '0;
        thr_sum     <= '0;
      end else begin
        grey_sum    <= grey_sum_next;
        pixel_tally <= pixel_tally_next;
        thr_sum     <= thr_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_frame.video_end <= s2_vend;
      s3_frame.grey_sum  <= grey_sum_next;
      s3_frame.thr_sum   <= thr_sum_next;
    end
  end

  // Frame judgment and run state
  fbs_run_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .frame_valid (s3_valid),
    .frame       (s3_frame),
    .select_dark (select_dark),
    .emit        (res_emit),
    .result      (res)
  );

  // Output register with skid behind it
  assign out_free = !out_valid || segments.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= en && res_emit;
      end
    end else if (en && res_emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (en && res_emit) begin
      skid_data <= res;
    end
  end

  assign segments.valid          = out_valid;
  assign segments.segment_number = out_data.segment_number;
  assign segments.start_frame    = out_data.start_frame;
  assign segments.frame_length   = out_data.frame_length;

endmodule

`default_nettype wire

// File: sv/fbs_checker.sv
// ----------------------------------------------------------------------------
// Frame brightness segmenter checker
// Port-level properties of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_brightness_segmenter_defines.svh"

module fbs_checker import fbs_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             seg_valid,
  input wire logic             seg_ready,
  input wire logic [SEG_W-1:0] seg_number,
  input wire logic [SEG_W-1:0] seg_start,
  input wire logic [SEG_W-1:0] seg_length
);

  // A stalled segment keeps its contents
  `FBS_ASSERT_NEXT(a_seg_hold, clk, rst, seg_valid && !seg_ready, seg_valid && $stable(seg_number) && $stable(seg_start) && $stable(seg_length), "segment changed while stalled")

  // Reset empties the output
  `FBS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !seg_valid && in_ready, "output not empty after reset")

  // Segments are numbered from one and span at least one frame
  `FBS_ASSERT_IMPLY(a_seg_nonzero, clk, rst, seg_valid, seg_number != '0 && seg_length != '0, "segment number or length is zero")

  // Pixels stall only behind a waiting segment
  `FBS_ASSERT_IMPLY(a_stall_cause, clk, rst, !in_ready, seg_valid && !$past(seg_ready), "pixel stall without a stalled segment")

endmodule

bind frame_brightness_segmenter fbs_checker u_fbs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixels.ready),
  .seg_valid  (segments.valid),
  .seg_ready  (segments.ready),
  .seg_number (segments.segment_number),
  .seg_start  (segments.start_frame),
  .seg_length (segments.frame_length)
);

`default_nettype wire

// File: bench/frame_brightness_segmenter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame brightness segmenter testbench
// Streams pixel frames and videos through the block under several threshold
// and polarity settings. A behavioral predictor tracks grey sums and frame
// runs, and each segment the block reports is compared against it.
// ----------------------------------------------------------------------------

module frame_brightness_segmenter_tb;
  import fbs_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_PIXELS   = 95;
  localparam int PRESSURE_PAIRS = 100;
  localparam longint TIMEOUT_NS = 64'd400_000 * 2 * CLK_HALF;

  // Luma weights, 14-bit fixed point, with rounding half
  localparam logic [31:0] LUMA_B     = 32'd1868;
  localparam logic [31:0] LUMA_G     = 32'd9617;
  localparam logic [31:0] LUMA_R     = 32'd4899;
  localparam logic [31:0] LUMA_HALF  = 32'd8192;
  localparam int          LUMA_SHIFT = 14;

  localparam logic [63:0] MAX32     = 64'hFFFF_FFFF;
  localparam logic [63:0] TALLY_CAP = 64'd1 << PIXEL_COUNT_BITS;
  localparam logic [63:0] FRAME_CAP =
    (FRAME_COUNT_BITS >= 32) ? MAX32 : (64'd1 << FRAME_COUNT_BITS) - 64'd1;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               frame_end;
    logic               video_end;
  } pixel_item_t;

  typedef enum logic [1:0] {RX_STREAM, RX_CHOPPY, RX_SLOW} rx_mode_t;
  typedef enum logic [1:0] {SHADE_BRIGHT, SHADE_DARK, SHADE_NOISE} shade_kind_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_request;

  fbs_pixel_if   pixels();
  fbs_segment_if segments();

  frame_brightness_segmenter i_dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .segments  (segments),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Pending pixels and segments still owed by the block
  pixel_item_t pixel_queue[$];
  segment_t    segment_expect[$];
  int          error_count = 0;

  // Register mirror and run state of the predictor
  logic [MEAN_W-1:0] thr_mirror;
  logic              dark_mirror;
  logic [63:0]       luma_total;
  logic [63:0]       pixel_count;
  logic [63:0]       frame_no;
  logic              run_live;
  logic [63:0]       run_first;
  logic [63:0]       run_frames;
  logic [63:0]       seg_count;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic restart_video();
    luma_total  = '0;
    pixel_count = '0;
    frame_no    = '0;
    run_live    = 1'b0;
    run_first   = '0;
    run_frames  = '0;
    seg_count   = 64'd1;
  endtask

  // Grey-convert one pixel, judge the frame at its end, close or report runs
  task automatic judge_pixel(input pixel_item_t px);
    logic [31:0] weighted;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic        hit;
    logic        emit;
    segment_t    seg;
    weighted = LUMA_B * px.blue + LUMA_G * px.green + LUMA_R * px.red + LUMA_HALF;
    if (pixel_count < TALLY_CAP) begin
      luma_total  += 64'(weighted >> LUMA_SHIFT);
      pixel_count += 64'd1;
    end
    if (px.frame_end || px.video_end) begin
      lhs = luma_total << 8;
      rhs = 64'(thr_mirror) * pixel_count;
      hit = dark_mirror ? (lhs <= rhs) : (lhs > rhs);
      if (hit) begin
        if (run_live) begin
          if (run_frames < MAX32) run_frames += 64'd1;
        end else begin
          run_live   = 1'b1;
          run_first  = frame_no;
          run_frames = 64'd1;
        end
        emit = px.video_end;
      end else begin
        emit = run_live;
      end
      if (emit) begin
        seg.segment_number = seg_count[SEG_W-1:0];
        seg.start_frame    = run_first[SEG_W-1:0];
        seg.frame_length   = run_frames[SEG_W-1:0];
        segment_expect.push_back(seg);
        run_live   = 1'b0;
        run_frames = '0;
        if (seg_count < MAX32) seg_count += 64'd1;
      end
      luma_total  = '0;
      pixel_count = '0;
      if (frame_no < FRAME_CAP) frame_no += 64'd1;
      if (px.video_end) restart_video();
    end
  endtask

  // Predict on every pixel transfer
  always @(posedge clk) begin
    if (!rst && pixels.valid && pixels.ready)
      judge_pixel(pixel_item_t'({pixels.blue, pixels.green, pixels.red,
                                 pixels.frame_end, pixels.video_end}));
  end

  // Pixel driver: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    pixel_item_t nxt;
    if (rst) begin
      pixels.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!pixels.valid || pixels.ready) begin
      if (gap_left != 0) begin
        gap_left--;
        pixels.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        nxt = pixel_queue.pop_front();
        pixels.blue      <= nxt.blue;
        pixels.green     <= nxt.green;
        pixels.red       <= nxt.red;
        pixels.frame_end <= nxt.frame_end;
        pixels.video_end <= nxt.video_end;
        pixels.valid     <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        pixels.valid <= 1'b0;
      end
    end
  end

  // Segment receiver: stall pattern of its own, plus one long hold-off
  rx_mode_t rx_mode;
  int       mode_left;
  int       hold_left;
  logic     hold_seen;
  always @(posedge clk) begin
    logic take;
    if (rst) begin
      segments.ready <= 1'b0;
      rx_mode        <= RX_STREAM;
      mode_left      <= 0;
      hold_left      <= 0;
      hold_seen      <= 1'b0;
    end else begin
      hold_seen <= hold_request;
      if (hold_request && !hold_seen) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)         hold_left <= hold_left - 1;
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_STREAM: take = 1'b1;
        RX_CHOPPY: take = $urandom_range(0, 1);
        default:   take = ($urandom_range(0, 3) == 0);
      endcase
      segments.ready <= take && (hold_left == 0);
    end
  end

  // Segment checker
  always @(posedge clk) begin
    segment_t want;
    if (!rst && segments.valid && segments.ready) begin
      if (segment_expect.size() == 0) begin
        report_mismatch($sformatf("segment %0d with nothing expected",
                                  segments.segment_number));
      end else begin
        want = segment_expect.pop_front();
        if (segments.segment_number !== want.segment_number)
          report_mismatch($sformatf("segment_number %0d, expected %0d",
                                    segments.segment_number, want.segment_number));
        if (segments.start_frame !== want.start_frame)
          report_mismatch($sformatf("start_frame %0d, expected %0d (segment %0d)",
                                    segments.start_frame, want.start_frame,
                                    want.segment_number));
        if (segments.frame_length !== want.frame_length)
          report_mismatch($sformatf("frame_length %0d, expected %0d (segment %0d)",
                                    segments.frame_length, want.frame_length,
                                    want.segment_number));
      end
    end
  end

  task automatic push_pixel(input int b, input int g, input int r,
                            input logic fend, input logic vend);
    pixel_item_t px;
    px.blue      = b[COLOR_W-1:0];
    px.green     = g[COLOR_W-1:0];
    px.red       = r[COLOR_W-1:0];
    px.frame_end = fend;
    px.video_end = vend;
    pixel_queue.push_back(px);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_setting(input logic [MEAN_W-1:0] thr, input logic dark);
    write_reg(REG_MEAN_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_SELECT_DARK, CFG_DATA_W'(dark));
    thr_mirror  = thr;
    dark_mirror = dark;
  endtask

  // Wait until every pixel is sent and every segment is back, then let the
  // pipeline settle for frames that report nothing
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || pixels.valid || segment_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int shade(input int level, input int jitter);
    int v;
    v = level + $urandom_range(0, 2 * jitter) - jitter;
    if (v < 0)   v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // Random videos of short frames; frame brightness sticks for a while so
  // that runs of several frames form
  task automatic queue_phase(input int budget);
    int          added;
    int          frames;
    int          npix;
    int          level;
    int          jitter;
    int          mid;
    logic        last_frame;
    logic        vend_only;
    shade_kind_t kind;
    added = 0;
    kind  = SHADE_BRIGHT;
    mid   = thr_mirror >> 8;
    while (added < budget) begin
      frames = $urandom_range(1, 24);
      for (int f = 0; f < frames; f++) begin
        last_frame = (f == frames - 1);
        vend_only  = last_frame && $urandom_range(0, 1);
        if ($urandom_range(0, 9) < 3) kind = shade_kind_t'($urandom_range(0, 2));
        npix   = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        jitter = $urandom_range(0, 1) ? 8 : 0;
        if (kind == SHADE_BRIGHT) level = (mid >= 255) ? 255 : $urandom_range(mid + 1, 255);
        else                      level = $urandom_range(0, mid);
        for (int p = 0; p < npix; p++) begin
          if (kind == SHADE_NOISE)
            push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), 1'b0, 1'b0);
          else
            push_pixel(shade(level, jitter), shade(level, jitter), shade(level, jitter),
                       1'b0, 1'b0);
        end
        // Mark the frame end, and on the last frame the video end, on its last pixel
        pixel_queue[$].frame_end = !vend_only;
        pixel_queue[$].video_end = last_frame;
        added += npix;
      end
    end
  endtask

  // Stimulus and run control
  initial begin
    logic [MEAN_W-1:0] thr;
    logic              dark;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_MEAN_THRESHOLD;
    cfg_data       = '0;
    hold_request   = 1'b0;
    pixels.valid     = 1'b0;
    pixels.blue      = '0;
    pixels.green     = '0;
    pixels.red       = '0;
    pixels.frame_end = 1'b0;
    pixels.video_end = 1'b0;
    segments.ready   = 1'b0;
    thr_mirror     = '0;
    dark_mirror    = 1'b0;
    restart_video();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: mean threshold of 128.0, bright frames qualify
    apply_setting(16'h8000, 1'b0);
    push_pixel(255, 255, 255, 1'b1, 1'b0);  // white frame opens a run
    push_pixel(0, 0, 0, 1'b1, 1'b0);        // black frame closes it
    push_pixel(128, 128, 128, 1'b1, 1'b0);  // mean exactly at threshold
    push_pixel(255, 0, 0, 1'b0, 1'b0);      // each channel alone at full scale
    push_pixel(0, 255, 0, 1'b0, 1'b0);
    push_pixel(0, 0, 255, 1'b1, 1'b0);
    push_pixel(255, 255, 255, 1'b0, 1'b0);  // mean 127.5, just under
    push_pixel(0, 0, 0, 1'b1, 1'b0);
    push_pixel(200, 200, 200, 1'b1, 1'b0);
    push_pixel(200, 200, 200, 1'b1, 1'b0);
    push_pixel(200, 200, 200, 1'b1, 1'b0);
    push_pixel(255, 255, 255, 1'b1, 1'b1);  // video ends inside an open run
    push_pixel(255, 255, 255, 1'b0, 1'b1);  // one-frame video, end without frame end
    push_pixel(0, 0, 0, 1'b1, 1'b1);        // dark one-frame video, nothing open
    push_pixel(10, 10, 10, 1'b0, 1'b1);
    push_pixel(255, 255, 255, 1'b1, 1'b0);
    push_pixel(0, 0, 0, 1'b1, 1'b0);
    push_pixel(250, 250, 250, 1'b1, 1'b0);
    push_pixel(250, 250, 250, 1'b0, 1'b1);  // second run closed by video end
    wait_drained();

    // Random phases, threshold and polarity extremes first
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       begin thr = 16'h0000; dark = 1'b0; end
        1:       begin thr = 16'h0000; dark = 1'b1; end
        2:       begin thr = 16'hFFFF; dark = 1'b0; end
        3:       begin thr = 16'hFFFF; dark = 1'b1; end
        4:       begin thr = 16'h8000; dark = 1'b1; end
        5:       begin thr = 16'h00FF; dark = 1'b0; end
        default: begin thr = $urandom_range(0, 65535); dark = $urandom_range(0, 1); end
      endcase
      apply_setting(thr, dark);
      queue_phase(PHASE_PIXELS);
      wait_drained();
    end

    // Back-pressure: the receiver holds off while one-pixel frames alternate
    // bright and dark, so segments pile up and the pixel input stalls
    apply_setting(16'h8000, 1'b0);
    hold_request <= 1'b1;
    for (int i = 0; i < PRESSURE_PAIRS; i++) begin
      push_pixel(255, 255, 255, 1'b1, 1'b0);
      push_pixel(0, 0, 0, 1'b1, 1'b0);
    end
    push_pixel(255, 255, 255, 1'b1, 1'b1);
    wait_drained();

    if (error_count == 0) begin
      $display("PASS frame_brightness_segmenter");
    end else begin
      $display("FAIL frame_brightness_segmenter");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("TIMEOUT: %0d pixels unsent, %0d segments outstanding",
             pixel_queue.size(), segment_expect.size());
    $display("FAIL frame_brightness_segmenter");
    $finish;
  end

endmodule
